[rtl/cvh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvh_pkg
// Shared types and constants of the convex hull block: point format, store
// sizing and the interface of the shared cross-product unit.
// ----------------------------------------------------------------------------
package cvh_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = PROD_W + 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // x in the low half, y in the high half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pt_t;

  typedef enum logic {
    XU_TURN,
    XU_DSQ
  } xu_mode_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } xu_res_t;

endpackage
`default_nettype wire

[rtl/cvh_xunit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvh_xunit
// Shared multiply-accumulate unit. Gives the sign of the cross product
// (b - a) x (c - a), or of |b - a|^2 - |c - a|^2, one product per cycle.
// ----------------------------------------------------------------------------
module cvh_xunit
  import cvh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire xu_mode_t mode,
  input  wire pt_t      pa,
  input  wire pt_t      pb,
  input  wire pt_t      pc,
  output xu_res_t       res
);

  logic signed [DIFF_W-1:0] dxb_r, dyb_r, dxc_r, dyc_r;
  logic signed [DIFF_W-1:0] op1, op2;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     tneg, neg_r;
  xu_mode_t                 mode_r;
  logic [2:0]               step_r, last_step;
  logic                     act_r, done_r;

  assign last_step = (mode_r == XU_DSQ) ? 3'd4 : 3'd2;

  always_comb begin
    op1  = dxb_r;
    op2  = dyc_r;
    tneg = 1'b0;
    if (mode_r == XU_TURN) begin
      if (step_r != 3'd0) begin
        op1  = dyb_r;
        op2  = dxc_r;
        tneg = 1'b1;
      end
    end else begin
      case (step_r)
        3'd0: begin
          op1 = dxb_r;
          op2 = dxb_r;
        end
        3'd1: begin
          op1 = dyb_r;
          op2 = dyb_r;
        end
        3'd2: begin
          op1  = dxc_r;
          op2  = dxc_r;
          tneg = 1'b1;
        end
        default: begin
          op1  = dyc_r;
          op2  = dyc_r;
          tneg = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (neg_r) begin
      acc_nxt = acc_r - {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end else begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dxb_r  <= {pb.x[COORD_W-1], pb.x} - {pa.x[COORD_W-1], pa.x};
        dyb_r  <= {pb.y[COORD_W-1], pb.y} - {pa.y[COORD_W-1], pa.y};
        dxc_r  <= {pc.x[COORD_W-1], pc.x} - {pa.x[COORD_W-1], pa.x};
        dyc_r  <= {pc.y[COORD_W-1], pc.y} - {pa.y[COORD_W-1], pa.y};
        mode_r <= mode;
        step_r <= 3'd0;
        acc_r  <= '0;
        act_r  <= 1'b1;
      end else if (act_r) begin
        if (step_r < last_step) begin
          prod_r <= op1 * op2;
          neg_r  <= tneg;
        end
        // accumulate the product of the previous step
        if (step_r != 3'd0) begin
          acc_r <= acc_nxt;
        end
        if (step_r == last_step) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  assign res.done = done_r;
  assign res.neg  = acc_r[ACC_W-1];
  assign res.zero = (acc_r == '0);

endmodule
`default_nettype wire

[rtl/convex_hull_graham_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Collects a set of points and, on the last one, emits its convex hull by a
// Graham scan built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | ports                                  | carries
//  --------+----------------------------------------+---------------------------
//  in      | in_valid/in_ready, point_x/y, last     | one point per item
//  out     | out_valid/out_ready, vertex_x/y, flags | one hull vertex per item
//
//  Points load one per cycle while the block is collecting.
//  After the last point: pivot search, then insertion sort with one turn
//  test or turn plus distance test per compare, then the scan with one turn
//  test per check, then the output of the hull vertices one by one.
//  The shared multiplier, one product a cycle, sets the compare cost.
//  in_ready is low from the last point until the final vertex is taken.
//  Reset empties the set; the point and stack memories are not cleared.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan
  import cvh_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic                      in_last_point,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_vertex_x,
  output logic signed [COORD_W-1:0]      out_vertex_y,
  output logic                           out_last_vertex,
  output logic                           out_overflowed
);

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_PV0, S_PV1, S_SWAP0, S_SWAP1,
    S_SORT_K1, S_SORT_CMP, S_SORT_TURN, S_SORT_DSQ, S_SORT_SHIFT, S_SORT_PLACE,
    S_SCAN_INIT, S_SCAN_INIT2, S_SCAN_C, S_SCAN_CHK, S_SCAN_A1, S_SCAN_A2,
    S_SCAN_B1, S_SCAN_B2, S_SCAN_TURN, S_SCAN_PUSH,
    S_FINAL, S_FIN1, S_FIN2, S_EM1, S_EM2, S_EMW
  } state_t;

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO = CNT_W'(2);

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r, i_r, j_r, size_r;
  logic             ovf_r, close_r;
  logic [IDX_W-1:0] piv_r;
  pt_t              best_r, p0_r, pivot_r, key_r, prev_r, a_pt_r, c_pt_r;
  pt_t              in_pt;
  logic             out_valid_r, out_last_r;
  pt_t              out_pt_r;

  // point store and hull stack
  pt_t              store_mem [MAX_POINTS];
  logic [IDX_W-1:0] stk_mem   [MAX_POINTS];
  pt_t              mem_rd_r;
  logic [IDX_W-1:0] stk_rd_r;
  logic             mem_we, stk_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr, stk_waddr, stk_raddr, stk_wdata;
  pt_t              mem_wdata;

  logic             xu_start;
  xu_mode_t         xu_mode;
  pt_t              xu_a, xu_b, xu_c;
  xu_res_t          xu_res;

  logic [CNT_W-1:0] i_inc, j_dec, size_dec, size_inc;
  logic             better, in_acc;

  assign in_pt    = {in_point_y, in_point_x};
  assign i_inc    = i_r + ONE;
  assign j_dec    = j_r - ONE;
  assign size_dec = size_r - ONE;
  assign size_inc = size_r + ONE;
  assign in_acc   = in_valid && in_ready;
  assign better   = (mem_rd_r.y < best_r.y) ||
                    ((mem_rd_r.y == best_r.y) && (mem_rd_r.x < best_r.x));

  cvh_xunit u_xunit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (xu_start),
    .mode  (xu_mode),
    .pa    (xu_a),
    .pb    (xu_b),
    .pc    (xu_c),
    .res   (xu_res)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = in_pt;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = size_r[IDX_W-1:0];
    stk_wdata = i_r[IDX_W-1:0];
    stk_raddr = '0;
    xu_start  = 1'b0;
    xu_mode   = XU_TURN;
    xu_a      = pivot_r;
    xu_b      = key_r;
    xu_c      = prev_r;
    case (state_r)
      S_LOAD: begin
        mem_we = in_acc && (cnt_r < MAX_CNT);
      end
      S_START: begin
        if (cnt_r == ONE) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '0;
        end
      end
      S_PV0:  mem_raddr = i_inc[IDX_W-1:0];
      S_PV1:  mem_raddr = i_inc[IDX_W-1:0];
      S_SWAP0: begin
        mem_we    = 1'b1;
        mem_waddr = piv_r;
        mem_wdata = p0_r;
      end
      S_SWAP1: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = best_r;
        mem_raddr = TWO[IDX_W-1:0];
      end
      // fetch the neighbour below the key
      S_SORT_K1: mem_raddr = i_r[IDX_W-1:0] - IDX_W'(1);
      S_SORT_CMP: begin
        xu_start = 1'b1;
        xu_c     = mem_rd_r;
      end
      S_SORT_TURN: begin
        if (xu_res.done && xu_res.zero) begin
          xu_start = 1'b1;
          xu_mode  = XU_DSQ;
        end
      end
      S_SORT_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IDX_W-1:0];
        mem_wdata = prev_r;
        mem_raddr = j_r[IDX_W-1:0] - IDX_W'(2);
      end
      S_SORT_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IDX_W-1:0];
        mem_wdata = key_r;
        mem_raddr = i_inc[IDX_W-1:0];
      end
      S_SCAN_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
      end
      S_SCAN_INIT2: begin
        stk_we    = 1'b1;
        stk_waddr = ONE[IDX_W-1:0];
        stk_wdata = ONE[IDX_W-1:0];
        mem_raddr = TWO[IDX_W-1:0];
      end
      S_SCAN_CHK: stk_raddr = size_r[IDX_W-1:0] - IDX_W'(2);
      S_SCAN_A1:  mem_raddr = stk_rd_r;
      S_SCAN_A2:  stk_raddr = size_dec[IDX_W-1:0];
      S_SCAN_B1:  mem_raddr = stk_rd_r;
      S_SCAN_B2: begin
        xu_start = 1'b1;
        xu_a     = a_pt_r;
        xu_b     = mem_rd_r;
        xu_c     = c_pt_r;
      end
      S_SCAN_PUSH: begin
        stk_we    = 1'b1;
        mem_raddr = i_inc[IDX_W-1:0];
      end
      S_FINAL: stk_raddr = size_dec[IDX_W-1:0];
      S_FIN1:  mem_raddr = stk_rd_r;
      S_FIN2:  stk_raddr = '0;
      S_EM1:   mem_raddr = stk_rd_r;
      S_EMW:   stk_raddr = i_inc[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= store_mem[mem_raddr];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      size_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_r < MAX_CNT) begin
              cnt_r <= cnt_r + ONE;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_point) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          i_r <= '0;
          if (cnt_r == ONE) begin
            size_r  <= ONE;
            state_r <= S_FINAL;
          end else begin
            state_r <= S_PV0;
          end
        end
        S_PV0: begin
          best_r  <= mem_rd_r;
          p0_r    <= mem_rd_r;
          piv_r   <= '0;
          i_r     <= ONE;
          state_r <= S_PV1;
        end
        S_PV1: begin
          if (better) begin
            best_r <= mem_rd_r;
            piv_r  <= i_r[IDX_W-1:0];
          end
          if (i_inc < cnt_r) begin
            i_r <= i_inc;
          end else begin
            state_r <= S_SWAP0;
          end
        end
        S_SWAP0: begin
          pivot_r <= best_r;
          state_r <= S_SWAP1;
        end
        S_SWAP1: begin
          i_r     <= TWO;
          state_r <= (cnt_r > TWO) ? S_SORT_K1 : S_SCAN_INIT;
        end
        S_SORT_K1: begin
          key_r   <= mem_rd_r;
          j_r     <= i_r;
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          prev_r  <= mem_rd_r;
          state_r <= S_SORT_TURN;
        end
        S_SORT_TURN: begin
          if (xu_res.done) begin
            if (xu_res.zero) begin
              state_r <= S_SORT_DSQ;
            end else if (xu_res.neg) begin
              state_r <= S_SORT_PLACE;
            end else begin
              state_r <= S_SORT_SHIFT;
            end
          end
        end
        S_SORT_DSQ: begin
          if (xu_res.done) begin
            state_r <= xu_res.neg ? S_SORT_SHIFT : S_SORT_PLACE;
          end
        end
        S_SORT_SHIFT: begin
          j_r     <= j_dec;
          state_r <= (j_dec > ONE) ? S_SORT_CMP : S_SORT_PLACE;
        end
        S_SORT_PLACE: begin
          if (i_inc < cnt_r) begin
            i_r     <= i_inc;
            state_r <= S_SORT_K1;
          end else begin
            state_r <= S_SCAN_INIT;
          end
        end
        S_SCAN_INIT: state_r <= S_SCAN_INIT2;
        S_SCAN_INIT2: begin
          size_r  <= TWO;
          i_r     <= TWO;
          state_r <= (cnt_r > TWO) ? S_SCAN_C : S_FINAL;
        end
        S_SCAN_C: begin
          c_pt_r  <= mem_rd_r;
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: state_r <= (size_r >= TWO) ? S_SCAN_A1 : S_SCAN_PUSH;
        S_SCAN_A1:  state_r <= S_SCAN_A2;
        S_SCAN_A2: begin
          a_pt_r  <= mem_rd_r;
          state_r <= S_SCAN_B1;
        end
        S_SCAN_B1: state_r <= S_SCAN_B2;
        S_SCAN_B2: state_r <= S_SCAN_TURN;
        S_SCAN_TURN: begin
          if (xu_res.done) begin
            if (xu_res.neg || xu_res.zero) begin
              // drop the top: not a strict left turn
              size_r  <= size_dec;
              state_r <= S_SCAN_CHK;
            end else begin
              state_r <= S_SCAN_PUSH;
            end
          end
        end
        S_SCAN_PUSH: begin
          size_r <= size_inc;
          i_r    <= i_inc;
          state_r <= (i_inc < cnt_r) ? S_SCAN_C : S_FINAL;
        end
        S_FINAL: state_r <= S_FIN1;
        S_FIN1:  state_r <= S_FIN2;
        S_FIN2: begin
          close_r <= (size_r > TWO) && (mem_rd_r != pivot_r);
          i_r     <= '0;
          state_r <= S_EM1;
        end
        S_EM1: state_r <= S_EM2;
        S_EM2: begin
          out_pt_r    <= mem_rd_r;
          out_last_r  <= (i_inc == size_r) && !close_r;
          out_valid_r <= 1'b1;
          state_r     <= S_EMW;
        end
        S_EMW: begin
          if (out_ready) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              cnt_r       <= '0;
              size_r      <= '0;
              ovf_r       <= 1'b0;
              state_r     <= S_LOAD;
            end else if (i_inc < size_r) begin
              out_valid_r <= 1'b0;
              i_r         <= i_inc;
              state_r     <= S_EM1;
            end else begin
              // close the polygon with the first vertex
              out_pt_r   <= pivot_r;
              out_last_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_ready        = (state_r == S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_vertex_x    = out_pt_r.x;
  assign out_vertex_y    = out_pt_r.y;
  assign out_last_vertex = out_last_r;
  assign out_overflowed  = ovf_r;

  a_out_in_emit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMW))
    else $error("result shown outside emit state");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("point count beyond capacity");

  a_run_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_vertex) |=>
      (cnt_r == '0 && !ovf_r && state_r == S_LOAD))
    else $error("set not cleared after final vertex");

  a_start_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |-> (cnt_r != '0))
    else $error("hull started on an empty set");

  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CHK) |-> (size_r >= ONE && size_r <= cnt_r))
    else $error("hull stack depth out of range");

endmodule
`default_nettype wire
